[sv/wcp_pkg.sv]
// Shared constants, codes and types for the wave cycle class profiler.
// No dependencies; design files that use it refer to it by scoped names, dv files import it.
package wcp_pkg;

  // Sizing
  localparam int MAX_WAVES  = 64;
  localparam int COUNT_BITS = 48;
  localparam int COST_BITS  = 32;

  localparam int WAVE_AW = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;

  // Fixed port field widths
  localparam int FUNC_W    = 2;
  localparam int WID_W     = 6;
  localparam int CLASS_W   = 4;
  localparam int COST_IN_W = 32;
  localparam int RES_W     = 48;

  // Wave id widened far enough to compare against MAX_WAVES and index any slot
  localparam int WID_EXT_W = ($clog2(MAX_WAVES + 1) > WID_W) ? $clog2(MAX_WAVES + 1) : WID_W;

  // Slot RAM word: {class, remaining cycles}
  localparam int SLOT_W = CLASS_W + COST_BITS;

  // Counter layout
  localparam int NUM_CLASSES  = 9;
  localparam int NUM_COUNTERS = 11;
  localparam int CNT_TOTAL    = 0;
  localparam int CNT_ISSUED   = 1;
  localparam int CNT_CLASS0   = 2;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ASSIGN   = 2'd0,
    FN_RUNNABLE = 2'd1,
    FN_COMPLETE = 2'd2,
    FN_TICK     = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic walk;      // issue slot read, advance walk index
    logic load_out;  // capture result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic any_present;
    logic walk_last;
  } dp_status_t;

endpackage

[sv/wcp_req_if.sv]
// Input channel of the wave cycle class profiler: valid/ready plus item fields.
// Depends on wcp_pkg for field widths.
interface wcp_req_if;
  logic                           valid;
  logic                           ready;
  logic [wcp_pkg::FUNC_W-1:0]     func;
  logic [wcp_pkg::WID_W-1:0]      wave_id;
  logic [wcp_pkg::CLASS_W-1:0]    work_class;
  logic [wcp_pkg::COST_IN_W-1:0]  cost;

  modport source (output valid, func, wave_id, work_class, cost, input ready);
  modport sink   (input valid, func, wave_id, work_class, cost, output ready);
endinterface

[sv/wcp_res_if.sv]
// Result channel of the wave cycle class profiler: done flag and eleven counters.
// Depends on wcp_pkg for field widths.
interface wcp_res_if;
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic [wcp_pkg::RES_W-1:0]  total_cycle_count;
  logic [wcp_pkg::RES_W-1:0]  issued_cycle_count;
  logic [wcp_pkg::RES_W-1:0]  scalar_alu_count;
  logic [wcp_pkg::RES_W-1:0]  vector_alu_count;
  logic [wcp_pkg::RES_W-1:0]  tensor_count;
  logic [wcp_pkg::RES_W-1:0]  shared_mem_count;
  logic [wcp_pkg::RES_W-1:0]  scalar_mem_count;
  logic [wcp_pkg::RES_W-1:0]  global_mem_count;
  logic [wcp_pkg::RES_W-1:0]  private_mem_count;
  logic [wcp_pkg::RES_W-1:0]  barrier_count;
  logic [wcp_pkg::RES_W-1:0]  wait_count;

  modport source (output valid, done_res, total_cycle_count, issued_cycle_count,
                  scalar_alu_count, vector_alu_count, tensor_count, shared_mem_count,
                  scalar_mem_count, global_mem_count, private_mem_count, barrier_count,
                  wait_count, input ready);
  modport sink   (input valid, done_res, total_cycle_count, issued_cycle_count,
                  scalar_alu_count, vector_alu_count, tensor_count, shared_mem_count,
                  scalar_mem_count, global_mem_count, private_mem_count, barrier_count,
                  wait_count, output ready);
endinterface

[sv/wcp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/wcp_ctrl.sv]
// Controller of the wave cycle class profiler: one-hot FSM and result valid.
// Depends on wcp_pkg; drives datapath commands, reads datapath status.
module wcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  wcp_pkg::dp_status_t status,
  output wcp_pkg::dp_cmd_t    cmd
);
  wcp_pkg::state_t state, state_next;
  logic accept, load;

  assign in_ready = (state == wcp_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == wcp_pkg::ST_EMIT) && (!out_valid || out_ready);

  assign cmd.accept   = accept;
  assign cmd.walk     = (state == wcp_pkg::ST_WALK);
  assign cmd.load_out = load;

  always_comb begin
    state_next = state;
    unique case (state)
      wcp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (status.is_tick && status.any_present) ? wcp_pkg::ST_WALK
                                                              : wcp_pkg::ST_EMIT;
        end
      end
      wcp_pkg::ST_WALK: begin
        if (status.walk_last) begin
          state_next = wcp_pkg::ST_FLUSH;
        end
      end
      wcp_pkg::ST_FLUSH: begin
        state_next = wcp_pkg::ST_EMIT;
      end
      wcp_pkg::ST_EMIT: begin
        if (load) begin
          state_next = wcp_pkg::ST_IDLE;
        end
      end
      default: state_next = wcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wcp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

[sv/wcp_datapath.sv]
// Datapath of the wave cycle class profiler: slot flags, slot RAM, walk pipe,
// profile counters and result register. Depends on wcp_pkg and wcp_ram.
module wcp_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  wcp_pkg::dp_cmd_t                  cmd,
  output wcp_pkg::dp_status_t               status,
  input  logic [wcp_pkg::FUNC_W-1:0]        func,
  input  logic [wcp_pkg::WID_W-1:0]         wave_id,
  input  logic [wcp_pkg::CLASS_W-1:0]       work_class,
  input  logic [wcp_pkg::COST_IN_W-1:0]     cost,
  output logic                              done_q,
  output wcp_pkg::count_t                   out_cnt [wcp_pkg::NUM_COUNTERS]
);
  logic [wcp_pkg::MAX_WAVES-1:0]  present, active;
  wcp_pkg::count_t                cnt [wcp_pkg::NUM_COUNTERS];
  logic [wcp_pkg::WAVE_AW-1:0]    idx, proc_idx, wid_idx, waddr;
  logic                           proc_valid, proc_hit, wid_ok, assign_hit, we;
  logic [wcp_pkg::WID_EXT_W-1:0]  wid_ext;
  logic [wcp_pkg::COST_BITS-1:0]  cost_in, rd_rem, rem_dec;
  logic [wcp_pkg::CLASS_W-1:0]    rd_class;
  logic [wcp_pkg::SLOT_W-1:0]     rdata, wdata;
  wcp_pkg::func_t                 fn;

  assign fn      = wcp_pkg::func_t'(func);
  assign wid_ext = wcp_pkg::WID_EXT_W'(wave_id);
  assign wid_ok  = wid_ext < wcp_pkg::WID_EXT_W'(wcp_pkg::MAX_WAVES);
  assign wid_idx = wid_ext[wcp_pkg::WAVE_AW-1:0];
  assign cost_in = wcp_pkg::COST_BITS'(cost);

  assign status.is_tick     = (fn == wcp_pkg::FN_TICK);
  assign status.any_present = |present;
  assign status.walk_last   = (idx == wcp_pkg::WAVE_AW'(wcp_pkg::MAX_WAVES - 1));

  // read data belongs to proc_idx (idx delayed by a register)
  assign rd_class = rdata[wcp_pkg::SLOT_W-1 -: wcp_pkg::CLASS_W];
  assign rd_rem   = rdata[wcp_pkg::COST_BITS-1:0];
  assign rem_dec  = rd_rem - wcp_pkg::COST_BITS'(1);
  assign proc_hit = proc_valid && present[proc_idx] && active[proc_idx] && (rd_rem != '0);

  assign assign_hit = cmd.accept && (fn == wcp_pkg::FN_ASSIGN) && wid_ok && (cost_in != '0);
  assign we         = assign_hit || proc_hit;
  assign waddr      = proc_hit ? proc_idx : wid_idx;
  assign wdata      = proc_hit ? {rd_class, rem_dec} : {work_class, cost_in};

  wcp_ram #(
    .WIDTH (wcp_pkg::SLOT_W),
    .DEPTH (wcp_pkg::MAX_WAVES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  // walk index and processing stage
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.walk;
    end
    proc_idx <= idx;
    if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.walk) begin
      idx <= idx + wcp_pkg::WAVE_AW'(1);
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      active  <= '0;
    end else begin
      if (cmd.accept && wid_ok) begin
        unique case (fn)
          wcp_pkg::FN_ASSIGN: begin
            present[wid_idx] <= 1'b1;
            active[wid_idx]  <= (cost_in != '0);
          end
          wcp_pkg::FN_RUNNABLE: begin
            present[wid_idx] <= 1'b1;
            active[wid_idx]  <= 1'b0;
          end
          wcp_pkg::FN_COMPLETE: begin
            present[wid_idx] <= 1'b0;
            active[wid_idx]  <= 1'b0;
          end
          wcp_pkg::FN_TICK: ;
        endcase
      end
      if (proc_hit && (rem_dec == '0)) begin
        active[proc_idx] <= 1'b0;
      end
    end
  end

  // profile counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < wcp_pkg::NUM_COUNTERS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (cmd.accept && status.is_tick && status.any_present) begin
        cnt[wcp_pkg::CNT_TOTAL] <= cnt[wcp_pkg::CNT_TOTAL] + wcp_pkg::COUNT_BITS'(1);
      end
      if (proc_hit) begin
        cnt[wcp_pkg::CNT_ISSUED] <= cnt[wcp_pkg::CNT_ISSUED] + wcp_pkg::COUNT_BITS'(1);
        for (int k = 0; k < wcp_pkg::NUM_CLASSES; k++) begin
          if (rd_class == wcp_pkg::CLASS_W'(k)) begin
            cnt[wcp_pkg::CNT_CLASS0 + k] <= cnt[wcp_pkg::CNT_CLASS0 + k]
                                            + wcp_pkg::COUNT_BITS'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      done_q  <= ~|present;
      out_cnt <= cnt;
    end
  end
endmodule

[sv/wave_cycle_class_profiler_unit.sv]
// Top level of the wave cycle class profiler: controller plus datapath.
// Depends on wcp_pkg, wcp_req_if, wcp_res_if, wcp_ctrl, wcp_datapath.

// Wave cycle class profiler. Keeps MAX_WAVES wave slots (present/active flags
// in flops, class and remaining cycles in a slot RAM) and eleven wrapping
// profile counters. Every accepted item yields exactly one result: a done flag
// (no slot present) and a snapshot of all counters. Items are taken one at a
// time. Assign, runnable, complete and a tick with no slot present go from
// accept to the emit state. A tick with a slot present walks all MAX_WAVES
// slots, flushes, then emits: the walk reads one slot per cycle through the
// single read port of the slot RAM and writes the decremented count back in
// the cycle after the read. The result sits in an output register; the next
// item is accepted while it waits to be taken, but its own result is held
// until the register is free. No clearing pass after reset.
module wave_cycle_class_profiler_unit (
  input logic        clk,
  input logic        rst,
  wcp_req_if.sink    req,
  wcp_res_if.source  res
);
  wcp_pkg::dp_cmd_t    cmd;
  wcp_pkg::dp_status_t status;
  logic                done_q;
  wcp_pkg::count_t     out_cnt [wcp_pkg::NUM_COUNTERS];

  wcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wcp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (req.func),
    .wave_id    (req.wave_id),
    .work_class (req.work_class),
    .cost       (req.cost),
    .done_q     (done_q),
    .out_cnt    (out_cnt)
  );

  // counter order: total, issued, then classes in work_class order
  assign res.done_res           = done_q;
  assign res.total_cycle_count  = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_TOTAL]);
  assign res.issued_cycle_count = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_ISSUED]);
  assign res.scalar_alu_count   = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 0]);
  assign res.vector_alu_count   = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 1]);
  assign res.tensor_count       = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 2]);
  assign res.shared_mem_count   = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 3]);
  assign res.scalar_mem_count   = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 4]);
  assign res.global_mem_count   = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 5]);
  assign res.private_mem_count  = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 6]);
  assign res.barrier_count      = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 7]);
  assign res.wait_count         = wcp_pkg::RES_W'(out_cnt[wcp_pkg::CNT_CLASS0 + 8]);
endmodule

[sv/wcp_checker.sv]
// Port-level checks for the wave cycle class profiler, bound to the top level.
// Depends on wcp_pkg and wave_cycle_class_profiler_unit.
module wcp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [wcp_pkg::FUNC_W-1:0]   req_func,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_done,
  input logic [wcp_pkg::RES_W-1:0]    res_total
);
  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // one item at a time: ready drops once an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("second item accepted while one is in progress");

  // a slot function with a free output register goes to emit, then raises res_valid
  a_slot_latency: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req_func != wcp_pkg::FN_TICK) && (!res_valid || res_ready)
    |=> ##1 res_valid)
    else $error("slot function result late");

  // assigning work to a slot leaves a present slot, so not done
  a_assign_not_done: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req_func == wcp_pkg::FN_ASSIGN) && (!res_valid || res_ready)
    |=> ##1 (res_valid && !res_done))
    else $error("done reported right after assign");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_total))
    else $error("stalled result changed");
endmodule

bind wave_cycle_class_profiler_unit wcp_checker u_wcp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.func),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_done  (res.done_res),
  .res_total (res.total_cycle_count)
);

[dv/wcp_profile_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the wave cycle class profiler: watches both channels, keeps a
// private slot table and counter set, and checks every result in arrival order.
// Depends on wcp_pkg, wcp_req_if and wcp_res_if.
module wcp_profile_checker (
  input  logic clk,
  input  logic rst,
  wcp_req_if   req,
  wcp_res_if   res,
  output int   fail_count,
  output int   outstanding,
  output int   items_seen,
  output int   walked_ticks,
  output int   done_results
);
  import wcp_pkg::*;

  typedef logic [NUM_COUNTERS-1:0][COUNT_BITS-1:0] counter_set_t;

  typedef struct packed {
    logic         done;
    counter_set_t cnt;
  } profile_snap_t;

  bit                   present   [MAX_WAVES];
  bit                   active    [MAX_WAVES];
  logic [CLASS_W-1:0]   wave_cls  [MAX_WAVES];
  logic [COST_BITS-1:0] remaining [MAX_WAVES];
  counter_set_t         counters;
  profile_snap_t        pending_snaps [$];
  int                   results_seen;

  string cnt_name [NUM_COUNTERS] = '{"total", "issued", "scalar_alu", "vector_alu",
                                     "tensor", "shared_mem", "scalar_mem", "global_mem",
                                     "private_mem", "barrier", "wait"};

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 30) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic bit table_occupied();
    for (int i = 0; i < MAX_WAVES; i++)
      if (present[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one item to the private table and returns the counters after it.
  function automatic profile_snap_t advance_profile(input func_t fn,
                                                    input logic [WID_W-1:0] wid,
                                                    input logic [CLASS_W-1:0] cls,
                                                    input logic [COST_IN_W-1:0] cost_in);
    logic [COST_BITS-1:0] cost;
    profile_snap_t        snap;
    int                   w;
    cost = COST_BITS'(cost_in);
    w    = int'(wid);
    if (fn == FN_TICK) begin
      if (table_occupied()) begin
        walked_ticks++;
        counters[CNT_TOTAL] += 1'b1;
        for (int i = 0; i < MAX_WAVES; i++) begin
          if (present[i] && active[i] && remaining[i] != 0) begin
            counters[CNT_ISSUED] += 1'b1;
            if (wave_cls[i] < NUM_CLASSES) counters[CNT_CLASS0 + int'(wave_cls[i])] += 1'b1;
            remaining[i] -= 1'b1;
            if (remaining[i] == 0) active[i] = 1'b0;
          end
        end
      end
    end else if (w < MAX_WAVES) begin
      case (fn)
        FN_ASSIGN: begin
          present[w] = 1'b1;
          if (cost == 0) begin
            active[w]    = 1'b0;
            remaining[w] = '0;
          end else begin
            active[w]    = 1'b1;
            wave_cls[w]  = cls;
            remaining[w] = cost;
          end
        end
        FN_RUNNABLE: begin
          present[w]   = 1'b1;
          active[w]    = 1'b0;
          remaining[w] = '0;
        end
        default: begin
          present[w]   = 1'b0;
          active[w]    = 1'b0;
          wave_cls[w]  = '0;
          remaining[w] = '0;
        end
      endcase
    end
    snap.done = !table_occupied();
    snap.cnt  = counters;
    return snap;
  endfunction

  always @(posedge clk) begin
    profile_snap_t got, want;
    if (rst) begin
      for (int i = 0; i < MAX_WAVES; i++) begin
        present[i]   = 1'b0;
        active[i]    = 1'b0;
        wave_cls[i]  = '0;
        remaining[i] = '0;
      end
      counters = '0;
      pending_snaps.delete();
    end else begin
      if (req.valid && req.ready) begin
        pending_snaps.push_back(advance_profile(func_t'(req.func), req.wave_id,
                                                req.work_class, req.cost));
        items_seen++;
      end
      if (res.valid && res.ready) begin
        got.done                      = res.done_res;
        got.cnt[CNT_TOTAL]            = res.total_cycle_count;
        got.cnt[CNT_ISSUED]           = res.issued_cycle_count;
        got.cnt[CNT_CLASS0 + 0]       = res.scalar_alu_count;
        got.cnt[CNT_CLASS0 + 1]       = res.vector_alu_count;
        got.cnt[CNT_CLASS0 + 2]       = res.tensor_count;
        got.cnt[CNT_CLASS0 + 3]       = res.shared_mem_count;
        got.cnt[CNT_CLASS0 + 4]       = res.scalar_mem_count;
        got.cnt[CNT_CLASS0 + 5]       = res.global_mem_count;
        got.cnt[CNT_CLASS0 + 6]       = res.private_mem_count;
        got.cnt[CNT_CLASS0 + 7]       = res.barrier_count;
        got.cnt[CNT_CLASS0 + 8]       = res.wait_count;
        if (pending_snaps.size() == 0) begin
          report_mismatch("result arrived with no item waiting for it");
        end else begin
          want = pending_snaps.pop_front();
          if (got.done !== want.done)
            report_mismatch($sformatf("result %0d: done got %b, expected %b",
                                      results_seen, got.done, want.done));
          for (int k = 0; k < NUM_COUNTERS; k++)
            if (got.cnt[k] !== want.cnt[k])
              report_mismatch($sformatf("result %0d: %s count got %0d, expected %0d",
                                        results_seen, cnt_name[k], got.cnt[k], want.cnt[k]));
          if (want.done) done_results++;
        end
        results_seen++;
      end
    end
    outstanding = pending_snaps.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the profiler testbench: clock, reset, item stimulus, result stalls,
// watchdog and verdict. Depends on wcp_pkg, the two channel interfaces,
// wcp_profile_checker and wave_cycle_class_profiler_unit.
module testbench;
  import wcp_pkg::*;

  // Work classes as the block numbers them; anything above the last one is
  // stored but never lands in a class counter.
  typedef enum logic [CLASS_W-1:0] {
    CL_SCALAR_ALU, CL_VECTOR_ALU, CL_TENSOR, CL_SHARED_MEM, CL_SCALAR_MEM,
    CL_GLOBAL_MEM, CL_PRIVATE_MEM, CL_BARRIER, CL_WAIT
  } work_class_e;
  localparam logic [CLASS_W-1:0] CLASS_OUT_OF_RANGE = 4'hF;

  localparam int STALL_PCT    = 28;    // chance that a side idles
  localparam int TARGET_ITEMS = 1400;
  localparam int STEADY_FIRST = 600;   // items in this window run with no idling
  localparam int STEADY_LAST  = 900;
  // A walking tick visits every slot; add stalls and gaps, then a wide margin.
  localparam int IDLE_LIMIT   = 4000;

  logic clk;
  logic rst;

  wcp_req_if req ();
  wcp_res_if res ();

  int fail_count, outstanding, items_seen, walked_ticks, done_results;
  int sent;
  int idle_cycles;
  bit steady;
  bit [MAX_WAVES-1:0] touched;   // slots this side has made present, for sweeps

  wave_cycle_class_profiler_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  wcp_profile_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .res          (res),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .items_seen   (items_seen),
    .walked_ticks (walked_ticks),
    .done_results (done_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops at random except inside the steady window.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // Watchdog: any cycle in which an item moves on either channel resets it.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short costs so waves drain to zero inside a burst; some zero costs
  // (idle assign) and a few full-width ones that only a complete can clear.
  function automatic logic [COST_IN_W-1:0] pick_cost();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 16) return COST_IN_W'($urandom);
    return COST_IN_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class();
    if ($urandom_range(99) < 85) return CLASS_W'($urandom_range(CL_SCALAR_ALU, CL_WAIT));
    return CLASS_W'($urandom_range(CL_WAIT + 1, CLASS_OUT_OF_RANGE));
  endfunction

  // Sends one item. valid is only lowered when a gap is taken, so back to back
  // items keep it high without a second assignment in the same step.
  task automatic send_item(input func_t fn, input logic [WID_W-1:0] wid,
                           input logic [CLASS_W-1:0] cls, input logic [COST_IN_W-1:0] cost);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= fn;
    req.wave_id    <= wid;
    req.work_class <= cls;
    req.cost       <= cost;
    do @(posedge clk); while (!req.ready);
    sent++;
    steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
    if (fn == FN_ASSIGN || fn == FN_RUNNABLE) touched[wid] = 1'b1;
    else if (fn == FN_COMPLETE) touched[wid] = 1'b0;
  endtask

  initial begin
    logic [WID_W-1:0] members [6];
    int               n_members;
    int               rounds;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.func       <= FN_ASSIGN;
    req.wave_id    <= '0;
    req.work_class <= '0;
    req.cost       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part ---
    // Tick on an empty table: no count moves, fields on a tick are ignored.
    send_item(FN_TICK, '1, CLASS_OUT_OF_RANGE, '1);
    // Completing a slot that was never present changes nothing.
    send_item(FN_COMPLETE, 6'd5, CL_BARRIER, 32'h1234);
    // Slot extremes, unit cost, a class past the last one, zero cost, runnable
    // with junk class/cost, and a full-width cost that never drains.
    send_item(FN_ASSIGN, 6'd0, CL_SCALAR_ALU, 32'd1);
    send_item(FN_ASSIGN, 6'd63, CL_WAIT, 32'd2);
    send_item(FN_ASSIGN, 6'd10, CLASS_OUT_OF_RANGE, 32'd3);
    send_item(FN_ASSIGN, 6'd20, CL_BARRIER, 32'd0);
    send_item(FN_RUNNABLE, 6'd21, CL_TENSOR, '1);
    send_item(FN_ASSIGN, 6'd30, CL_SCALAR_MEM, '1);
    send_item(FN_ASSIGN, 6'd31, CL_VECTOR_ALU, 32'd2);
    send_item(FN_ASSIGN, 6'd32, CL_SHARED_MEM, 32'd1);
    send_item(FN_ASSIGN, 6'd33, CL_GLOBAL_MEM, 32'd1);
    send_item(FN_ASSIGN, 6'd34, CL_PRIVATE_MEM, 32'd2);
    send_item(FN_ASSIGN, 6'd35, CL_TENSOR, 32'd1);
    repeat (3) send_item(FN_TICK, 6'd0, '0, '0);
    // Reassign a drained slot in place, then idle the long-running one.
    send_item(FN_ASSIGN, 6'd0, CL_VECTOR_ALU, 32'd2);
    send_item(FN_RUNNABLE, 6'd30, CL_SCALAR_ALU, 32'd7);
    send_item(FN_TICK, 6'd17, CL_WAIT, 32'd9);
    // Clear everything so done comes back, then one more empty tick.
    for (int w = 0; w < MAX_WAVES; w++)
      if (touched[w]) send_item(FN_COMPLETE, WID_W'(w), '1, '1);
    send_item(FN_TICK, '0, '0, '0);

    // --- Random part ---
    // Three in four rounds are a burst: load a few waves, tick them, retire
    // them. The rest is noise on every field. Now and then every slot still
    // present is swept away so done and the empty-table tick come back.
    while (sent < TARGET_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        n_members = $urandom_range(1, 6);
        for (int k = 0; k < n_members; k++) begin
          members[k] = WID_W'($urandom_range(0, MAX_WAVES - 1));
          send_item(FN_ASSIGN, members[k], pick_class(), pick_cost());
        end
        rounds = $urandom_range(1, 8);
        for (int k = 0; k < rounds; k++) begin
          if ($urandom_range(99) < 20) begin
            if ($urandom_range(1) == 1)
              send_item(FN_ASSIGN, members[$urandom_range(0, n_members - 1)],
                        pick_class(), pick_cost());
            else
              send_item(FN_RUNNABLE, members[$urandom_range(0, n_members - 1)],
                        CLASS_W'($urandom), COST_IN_W'($urandom));
          end
          send_item(FN_TICK, WID_W'($urandom), CLASS_W'($urandom), COST_IN_W'($urandom));
        end
        for (int k = 0; k < n_members; k++)
          if ($urandom_range(99) < 80)
            send_item(FN_COMPLETE, members[k], CLASS_W'($urandom), COST_IN_W'($urandom));
      end else begin
        send_item(func_t'($urandom_range(FN_ASSIGN, FN_TICK)), WID_W'($urandom),
                  CLASS_W'($urandom), pick_cost());
      end
      if ($urandom_range(99) < 30)
        for (int w = 0; w < MAX_WAVES; w++)
          if (touched[w]) send_item(FN_COMPLETE, WID_W'(w), CLASS_W'($urandom), '0);
    end
    req.valid <= 1'b0;

    // Drain: let the scoreboard see the last item, then wait for every result;
    // the watchdog bounds this wait.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_WAVES + 8) @(posedge clk);

    $display("Run covered %0d items, %0d ticks that walked a nonempty table,",
             items_seen, walked_ticks);
    $display("and %0d results reporting an empty table; %0d mismatches.",
             done_results, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
